// ===== sv/two_wire_register_master_core_defines.svh =====
// assertion macros for the two-wire register master checker
// expects signals clk and arst_n in the scope that uses them
`ifndef TWO_WIRE_REGISTER_MASTER_CORE_DEFINES_SVH
`define TWO_WIRE_REGISTER_MASTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TWRM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("two-wire master check failed");

// next-cycle implication, disabled during reset
`define TWRM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("two-wire master check failed");

`endif

// ===== sv/twrm_pkg.sv =====
// shared types and constants of the two-wire register master
// no dependencies
package twrm_pkg;

	localparam int TPU_W = 16;
	localparam logic [TPU_W-1:0] TICKS_RESET = 16'd100;
	localparam logic [7:0] MSB_MASK = 8'h80;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] reg_byte;
		logic [7:0] wr_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
	} res_t;

	typedef enum logic [17:0] {
		PH_IDLE    = 18'h00001,
		PH_START_A = 18'h00002,
		PH_START_B = 18'h00004,
		PH_START_C = 18'h00008,
		PH_TX_SET  = 18'h00010,
		PH_TX_HIGH = 18'h00020,
		PH_TX_LOW  = 18'h00040,
		PH_TX_REL  = 18'h00080,
		PH_TX_CLK  = 18'h00100,
		PH_ACK     = 18'h00200,
		PH_ACK_END = 18'h00400,
		PH_RX_HIGH = 18'h00800,
		PH_RX_LOW  = 18'h01000,
		PH_RX_END  = 18'h02000,
		PH_RD_DRV  = 18'h04000,
		PH_STOP_A  = 18'h08000,
		PH_STOP_B  = 18'h10000,
		PH_FINISH  = 18'h20000
	} phase_t;

endpackage

// ===== sv/twrm_engine.sv =====
// bus sequencer of the two-wire register master: one tick per step
// depends on twrm_pkg
module twrm_engine import twrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  item_t            item,
	input  logic [TPU_W-1:0] ticks_per_unit,
	output res_t             res
);

	phase_t           phase_q, phase_n;
	logic [TPU_W-1:0] unit_timer_q, unit_timer_n;
	logic [2:0]       delay_units_q, delay_units_n;
	logic [3:0]       bit_count_q, bit_count_n;
	logic [7:0]       shift_byte_q, shift_byte_n;
	logic [7:0]       held_data_q, held_data_n;
	logic             is_read_q, is_read_n;
	logic             scl_level_q, scl_level_n;
	logic             sda_latch_q, sda_latch_n;
	logic             sda_driving_q, sda_driving_n;
	logic [7:0]       read_byte_q, read_byte_n;
	logic             second_byte_q, second_byte_n;
	logic             done;
	logic             go;
	logic [TPU_W-1:0] limit;

	always_comb begin
		phase_n       = phase_q;
		unit_timer_n  = unit_timer_q;
		delay_units_n = delay_units_q;
		bit_count_n   = bit_count_q;
		shift_byte_n  = shift_byte_q;
		held_data_n   = held_data_q;
		is_read_n     = is_read_q;
		scl_level_n   = scl_level_q;
		sda_latch_n   = sda_latch_q;
		sda_driving_n = sda_driving_q;
		read_byte_n   = read_byte_q;
		second_byte_n = second_byte_q;
		done          = 1'b0;
		go            = 1'b0;
		limit         = (ticks_per_unit == '0) ? TPU_W'(1) : ticks_per_unit;

		// time base: start a request, count down a delay, or run at once
		if (phase_q == PH_IDLE) begin
			if (item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
				is_read_n     = (item.req_type == REQ_READ);
				shift_byte_n  = item.reg_byte;
				held_data_n   = item.wr_data;
				second_byte_n = 1'b0;
				bit_count_n   = '0;
				delay_units_n = '0;
				unit_timer_n  = '0;
				phase_n       = PH_START_A;
				go            = 1'b1;
			end
		end else if (delay_units_q != '0) begin
			unit_timer_n = unit_timer_q + TPU_W'(1);
			if (unit_timer_n >= limit) begin
				unit_timer_n  = '0;
				delay_units_n = delay_units_q - 3'd1;
			end
			go = (delay_units_n == '0);
		end else begin
			go = 1'b1;
		end

		if (go) begin
			case (phase_n)
				PH_IDLE: begin
				end
				PH_START_A: begin
					sda_latch_n = 1'b1;
					scl_level_n = 1'b1;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_START_B;
				end
				PH_START_B: begin
					sda_latch_n = 1'b0;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_START_C;
				end
				PH_START_C: begin
					scl_level_n = 1'b0;
					bit_count_n = '0;
					delay_units_n = 3'd2; unit_timer_n = '0; phase_n = PH_TX_SET;
				end
				PH_TX_SET: begin
					sda_latch_n = ((shift_byte_n & MSB_MASK) != '0);
					delay_units_n = 3'd3; unit_timer_n = '0; phase_n = PH_TX_HIGH;
				end
				PH_TX_HIGH: begin
					scl_level_n = 1'b1;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_TX_LOW;
				end
				PH_TX_LOW: begin
					scl_level_n  = 1'b0;
					shift_byte_n = {shift_byte_n[6:0], 1'b0};
					bit_count_n  = bit_count_n + 4'd1;
					delay_units_n = (bit_count_n < 4'd8) ? 3'd2 : 3'd5;
					unit_timer_n  = '0;
					phase_n = (bit_count_n < 4'd8) ? PH_TX_SET : PH_TX_REL;
				end
				PH_TX_REL: begin
					sda_driving_n = 1'b0;
					delay_units_n = 3'd1; unit_timer_n = '0; phase_n = PH_TX_CLK;
				end
				PH_TX_CLK: begin
					// clock goes high and the acknowledge is sampled on the same tick
					scl_level_n = 1'b1;
					if (!item.sda_in) begin
						delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_ACK_END;
					end else begin
						phase_n = PH_ACK;
					end
				end
				PH_ACK: begin
					if (!item.sda_in) begin
						delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_ACK_END;
					end
				end
				PH_ACK_END: begin
					scl_level_n = 1'b0;
					unit_timer_n = '0;
					if (is_read_n) begin
						bit_count_n  = '0;
						shift_byte_n = '0;
						delay_units_n = 3'd5; phase_n = PH_RX_HIGH;
					end else if (!second_byte_n) begin
						sda_driving_n = 1'b1;
						shift_byte_n  = held_data_n;
						second_byte_n = 1'b1;
						bit_count_n   = '0;
						delay_units_n = 3'd2; phase_n = PH_TX_SET;
					end else begin
						sda_driving_n = 1'b1;
						delay_units_n = 3'd5; phase_n = PH_STOP_A;
					end
				end
				PH_RX_HIGH: begin
					scl_level_n  = 1'b1;
					shift_byte_n = {shift_byte_n[6:0], item.sda_in};
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_RX_LOW;
				end
				PH_RX_LOW: begin
					scl_level_n = 1'b0;
					bit_count_n = bit_count_n + 4'd1;
					delay_units_n = 3'd5; unit_timer_n = '0;
					phase_n = (bit_count_n < 4'd8) ? PH_RX_HIGH : PH_RX_END;
				end
				PH_RX_END: begin
					scl_level_n = 1'b1;
					read_byte_n = shift_byte_n;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_RD_DRV;
				end
				PH_RD_DRV: begin
					sda_driving_n = 1'b1;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_STOP_A;
				end
				PH_STOP_A: begin
					scl_level_n = 1'b1;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_STOP_B;
				end
				PH_STOP_B: begin
					sda_latch_n = 1'b1;
					delay_units_n = 3'd5; unit_timer_n = '0; phase_n = PH_FINISH;
				end
				PH_FINISH: begin
					phase_n = PH_IDLE;
					done    = 1'b1;
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			unit_timer_q  <= '0;
			delay_units_q <= '0;
			bit_count_q   <= '0;
			shift_byte_q  <= '0;
			held_data_q   <= '0;
			is_read_q     <= 1'b0;
			scl_level_q   <= 1'b1;
			sda_latch_q   <= 1'b1;
			sda_driving_q <= 1'b1;
			read_byte_q   <= '0;
			second_byte_q <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_n;
			unit_timer_q  <= unit_timer_n;
			delay_units_q <= delay_units_n;
			bit_count_q   <= bit_count_n;
			shift_byte_q  <= shift_byte_n;
			held_data_q   <= held_data_n;
			is_read_q     <= is_read_n;
			scl_level_q   <= scl_level_n;
			sda_latch_q   <= sda_latch_n;
			sda_driving_q <= sda_driving_n;
			read_byte_q   <= read_byte_n;
			second_byte_q <= second_byte_n;
		end
	end

	assign res.scl       = scl_level_n;
	assign res.sda_out   = sda_latch_n;
	assign res.sda_drive = sda_driving_n;
	assign res.busy_res  = (phase_n != PH_IDLE);
	assign res.done_res  = done;
	assign res.rd_data   = read_byte_n;

endmodule

// ===== sv/two_wire_register_master_core.sv =====
// top level of the two-wire register master: input stage, sequencer, result queue
// depends on twrm_pkg and twrm_engine
//
// usage
//   every transfer on the item channel is one tick of the bus time base;
//   req_type starts a register write or read when the master is idle and is
//   ignored otherwise, sda_in carries the sampled data line for that tick
//   every item yields exactly one transfer on the res channel with the line
//   levels (scl, sda_out, sda_drive), busy/done flags and the last read byte
//   as they stand after that tick
//   cfg_we/cfg_data write ticks_per_unit (ticks per 10 us unit, reset 100)
// timing
//   an accepted item waits in the input register, then passes through the
//   sequencer into the result queue; throughput is one item per cycle while
//   the result queue is not full
// reset
//   arst_n clears the input stage and the queue; the bus idles with scl,
//   sda_out and sda_drive high
// stall
//   a two-entry result queue absorbs a stalled receiver; item_stall rises
//   only once the queue is full and the input register holds a waiting item
module two_wire_register_master_core import twrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// item channel
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	// result channel
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	// configuration write
	input  logic             cfg_we,
	input  logic [TPU_W-1:0] cfg_data
);

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	logic [TPU_W-1:0] tpu_q;

	// input register
	logic  item_valid_s1;
	item_t item_s1;

	// result queue
	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic  full;
	logic  push;
	logic  pop;
	logic  accept;
	res_t  step_res;

	assign full       = (count_q == CNT_W'(FIFO_DEPTH));
	assign push       = item_valid_s1 && !full;
	assign pop        = res_valid && !res_stall;
	assign item_stall = item_valid_s1 && full;
	assign accept     = item_valid && !item_stall;

	// ticks_per_unit register, a new value applies from the next tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TICKS_RESET;
		end else if (cfg_we) begin
			tpu_q <= cfg_data;
		end
	end

	// input stage: holds one item until the queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (push) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// sequencer advances one tick each time its result enters the queue
	twrm_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (push),
		.item           (item_s1),
		.ticks_per_unit (tpu_q),
		.res            (step_res)
	);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= step_res;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign res_valid = (count_q != '0);
	assign res       = fifo_q[rd_ptr_q];

endmodule

// ===== sv/twrm_checker.sv =====
// port-level checks for the two-wire register master, bound to the top level
// depends on twrm_pkg and two_wire_register_master_core_defines.svh
`include "two_wire_register_master_core_defines.svh"

module twrm_checker import twrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// a stalled result stays offered and unchanged
	`TWRM_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`TWRM_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res))

	// input backs up only behind a waiting result
	`TWRM_ASSERT_NOW(a_stall_needs_res, item_stall, res_valid)

	// finishing tick leaves the master idle
	`TWRM_ASSERT_NOW(a_done_idle, res_valid && res.done_res, !res.busy_res)

	// the data line is released only inside a transaction
	`TWRM_ASSERT_NOW(a_release_busy, res_valid && !res.sda_drive, res.busy_res)

endmodule

bind two_wire_register_master_core twrm_checker u_twrm_checker (.*);

// ===== sim/two_wire_register_master_core_tb.sv =====
// self-checking testbench for two_wire_register_master_core
// predicts every result from its own bus sequencer model; needs twrm_pkg and the core
module two_wire_register_master_core_tb;
	import twrm_pkg::*;

	// request code with no meaning, the block treats it as a plain tick
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// cycles with no transfer on either channel before the run is called hung
	localparam int QUIET_LIMIT = 4000;
	// cycles the block needs to settle after its last result
	localparam int SETTLE_CYCLES = 3;

	// predicted sequencer state, mirrors the block's bus engine
	typedef struct packed {
		phase_t     ph;
		logic [15:0] timer;
		logic [2:0] units;
		logic [3:0] nbits;
		logic [7:0] shreg;
		logic [7:0] wdata;
		logic       rd;
		logic       second;
		logic       scl;
		logic       sda;
		logic       drv;
		logic [7:0] rbyte;
	} master_st_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;
	logic             cfg_we = 1'b0;
	logic [TPU_W-1:0] cfg_data = '0;

	master_st_t       bus;
	logic [15:0]      rate;
	res_t             levels_due[$];
	res_t             due;
	int               tx_pct = 0;
	int               rx_pct = 0;
	int               errors = 0;
	int               quiet = 0;
	int               ticks_sent = 0;
	int               writes_started = 0;
	int               reads_started = 0;
	int               finished = 0;

	two_wire_register_master_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// bus sequencer prediction
	// ---------------------------------------------------------------

	// arm a delay of n timing units, then move to nx
	function automatic master_st_t hold_units(master_st_t s, logic [2:0] n, phase_t nx);
		s.units = n;
		s.timer = '0;
		s.ph = nx;
		return s;
	endfunction

	// one tick of the time base: returns the new state, r gets the line levels after it
	function automatic master_st_t bus_step(input master_st_t s, input logic [15:0] tpu,
			input item_t it, output res_t r);
		logic [15:0] lim;
		logic        go;
		logic        fin;
		logic        halt;
		lim = (tpu == 16'd0) ? 16'd1 : tpu;
		go = 1'b0;
		fin = 1'b0;
		halt = 1'b0;
		if (s.ph == PH_IDLE) begin
			// requests only start from idle, code three falls through as a tick
			if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
				s.rd = (it.req_type == REQ_READ);
				s.shreg = it.reg_byte;
				s.wdata = it.wr_data;
				s.second = 1'b0;
				s.nbits = '0;
				s.units = '0;
				s.timer = '0;
				s.ph = PH_START_A;
				go = 1'b1;
			end
		end else if (s.units != 3'd0) begin
			// a lowered rate takes effect at once, timer at or above it ends the unit
			s.timer = s.timer + 16'd1;
			if (s.timer >= lim) begin
				s.timer = '0;
				s.units = s.units - 3'd1;
			end
			go = (s.units == 3'd0);
		end else begin
			go = 1'b1;
		end
		for (int g = 0; g < 8 && go && !halt && s.ph != PH_IDLE; g++) begin
			// every action ends the tick except raising scl for the acknowledge
			halt = 1'b1;
			case (s.ph)
				PH_START_A: begin
					s.sda = 1'b1;
					s.scl = 1'b1;
					s = hold_units(s, 3'd5, PH_START_B);
				end
				PH_START_B: begin
					s.sda = 1'b0;
					s = hold_units(s, 3'd5, PH_START_C);
				end
				PH_START_C: begin
					s.scl = 1'b0;
					s.nbits = '0;
					s = hold_units(s, 3'd2, PH_TX_SET);
				end
				PH_TX_SET: begin
					s.sda = |(s.shreg & MSB_MASK);
					s = hold_units(s, 3'd3, PH_TX_HIGH);
				end
				PH_TX_HIGH: begin
					s.scl = 1'b1;
					s = hold_units(s, 3'd5, PH_TX_LOW);
				end
				PH_TX_LOW: begin
					s.scl = 1'b0;
					s.shreg = {s.shreg[6:0], 1'b0};
					s.nbits = s.nbits + 4'd1;
					if (s.nbits < 4'd8) begin
						s = hold_units(s, 3'd2, PH_TX_SET);
					end else begin
						s = hold_units(s, 3'd5, PH_TX_REL);
					end
				end
				PH_TX_REL: begin
					s.drv = 1'b0;
					s = hold_units(s, 3'd1, PH_TX_CLK);
				end
				PH_TX_CLK: begin
					s.scl = 1'b1;
					s.ph = PH_ACK;
					halt = 1'b0;
				end
				PH_ACK: begin
					// no timeout, waits with scl high until the slave pulls sda low
					if (!it.sda_in) begin
						s = hold_units(s, 3'd5, PH_ACK_END);
					end
				end
				PH_ACK_END: begin
					s.scl = 1'b0;
					if (s.rd) begin
						s.nbits = '0;
						s.shreg = '0;
						s = hold_units(s, 3'd5, PH_RX_HIGH);
					end else if (!s.second) begin
						s.drv = 1'b1;
						s.shreg = s.wdata;
						s.second = 1'b1;
						s.nbits = '0;
						s = hold_units(s, 3'd2, PH_TX_SET);
					end else begin
						s.drv = 1'b1;
						s = hold_units(s, 3'd5, PH_STOP_A);
					end
				end
				PH_RX_HIGH: begin
					s.scl = 1'b1;
					s.shreg = {s.shreg[6:0], it.sda_in};
					s = hold_units(s, 3'd5, PH_RX_LOW);
				end
				PH_RX_LOW: begin
					s.scl = 1'b0;
					s.nbits = s.nbits + 4'd1;
					if (s.nbits < 4'd8) begin
						s = hold_units(s, 3'd5, PH_RX_HIGH);
					end else begin
						s = hold_units(s, 3'd5, PH_RX_END);
					end
				end
				PH_RX_END: begin
					s.scl = 1'b1;
					s.rbyte = s.shreg;
					s = hold_units(s, 3'd5, PH_RD_DRV);
				end
				PH_RD_DRV: begin
					s.drv = 1'b1;
					s = hold_units(s, 3'd5, PH_STOP_A);
				end
				PH_STOP_A: begin
					s.scl = 1'b1;
					s = hold_units(s, 3'd5, PH_STOP_B);
				end
				PH_STOP_B: begin
					// sda kept its last driven bit until here
					s.sda = 1'b1;
					s = hold_units(s, 3'd5, PH_FINISH);
				end
				PH_FINISH: begin
					s.ph = PH_IDLE;
					fin = 1'b1;
				end
				default: begin
					s.ph = PH_IDLE;
				end
			endcase
		end
		r.scl = s.scl;
		r.sda_out = s.sda;
		r.sda_drive = s.drv;
		r.busy_res = (s.ph != PH_IDLE);
		r.done_res = fin;
		r.rd_data = s.rbyte;
		return s;
	endfunction

	// would a plain tick end the running transaction right now
	function automatic bit ends_now(item_t it);
		master_st_t t;
		res_t       r;
		it.req_type = REQ_TICK;
		t = bus_step(bus, rate, it, r);
		return r.done_res;
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (levels_due.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				due = levels_due.pop_front();
				check_field("scl", 8'(due.scl), 8'(res.scl));
				check_field("sda_out", 8'(due.sda_out), 8'(res.sda_out));
				check_field("sda_drive", 8'(due.sda_drive), 8'(res.sda_drive));
				check_field("busy_res", 8'(due.busy_res), 8'(res.busy_res));
				check_field("done_res", 8'(due.done_res), 8'(res.done_res));
				check_field("rd_data", due.rd_data, res.rd_data);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < rx_pct);
	end

	// hang detection: no transfer on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", quiet);
				$display("status: fail");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// one tick transfer; the expectation is formed at the accepting edge
	task automatic send_tick(input item_t it);
		res_t r;
		while ($urandom_range(99) < tx_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		if (bus.ph == PH_IDLE && it.req_type == REQ_WRITE) writes_started++;
		if (bus.ph == PH_IDLE && it.req_type == REQ_READ) reads_started++;
		bus = bus_step(bus, rate, it, r);
		levels_due.push_back(r);
		ticks_sent++;
		if (r.done_res) finished++;
	endtask

	task automatic wait_results();
		item_valid <= 1'b0;
		while (levels_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// rate register is only touched with all results in
	task automatic set_rate(input logic [15:0] v);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate = v;
	endtask

	// ticks until the running transaction ends: the slave holds each acknowledge
	// off for ack_hold ticks, read bits come from fill (0, 1, or 2 for random);
	// poke throws requests at the busy master, also on the tick that finishes
	task automatic finish_transaction(input int ack_hold, input int fill, input bit poke);
		item_t it;
		int    held;
		held = 0;
		while (bus.ph != PH_IDLE) begin
			it.req_type = REQ_TICK;
			it.reg_byte = 8'($urandom_range(255));
			it.wr_data = 8'($urandom_range(255));
			if (bus.ph == PH_TX_CLK || bus.ph == PH_ACK) begin
				it.sda_in = (held < ack_hold);
				held++;
			end else begin
				held = 0;
				it.sda_in = (fill == 2) ? 1'($urandom_range(1)) : 1'(fill);
			end
			if (poke) begin
				if (ends_now(it)) begin
					it.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
				end else if ($urandom_range(3) == 0) begin
					it.req_type = 2'($urandom_range(3));
				end
			end
			send_tick(it);
		end
	endtask

	// one whole transaction from its request
	task automatic run_transaction(input logic [1:0] req, input logic [7:0] addr,
			input logic [7:0] data, input int ack_hold, input int fill, input bit poke);
		item_t it;
		it.req_type = req;
		it.reg_byte = addr;
		it.wr_data = data;
		it.sda_in = 1'b1;
		send_tick(it);
		finish_transaction(ack_hold, fill, poke);
	endtask

	// random tick shaped by the predicted phase; start_ok lets it open transactions
	function automatic item_t random_tick(bit start_ok);
		item_t it;
		int    k;
		k = $urandom_range(99);
		it.reg_byte = 8'($urandom_range(255));
		it.wr_data = 8'($urandom_range(255));
		if (bus.ph == PH_IDLE) begin
			if (start_ok && k < 55) begin
				it.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
			end else if (k < 65) begin
				it.req_type = REQ_UNUSED;
			end else begin
				it.req_type = REQ_TICK;
			end
		end else if (k < 10) begin
			it.req_type = 2'($urandom_range(3));
		end else begin
			it.req_type = REQ_TICK;
		end
		// slave holds the acknowledge off now and then
		if (bus.ph == PH_TX_CLK || bus.ph == PH_ACK) begin
			it.sda_in = ($urandom_range(99) < 55);
		end else begin
			it.sda_in = 1'($urandom_range(1));
		end
		if (bus.ph != PH_IDLE && $urandom_range(1) && ends_now(it)) begin
			it.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
		end
		return it;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// idle ticks, the unused request code, then a read of all ones that starts
	// at the reset rate and drops to one tick per unit inside the start delay
	task automatic test_reset_rate();
		item_t it;
		for (int i = 0; i < 4; i++) begin
			it = random_tick(1'b0);
			it.req_type = (i % 2) ? REQ_UNUSED : REQ_TICK;
			it.sda_in = i[0];
			send_tick(it);
		end
		it.req_type = REQ_READ;
		it.reg_byte = 8'h3c;
		it.wr_data = 8'h00;
		it.sda_in = 1'b1;
		send_tick(it);
		// one full unit at the reset rate and part of the next
		it.req_type = REQ_TICK;
		for (int i = 0; i < 105; i++) begin
			send_tick(it);
		end
		// partly counted unit is already above the new rate and ends at once
		set_rate(16'd1);
		finish_transaction(0, 1, 1'b0);
	endtask

	// address and data extremes, and an acknowledge held off for a while
	task automatic test_write_extremes();
		set_rate(16'd1);
		run_transaction(REQ_WRITE, 8'hff, 8'h00, 25, 2, 1'b0);
	endtask

	// zero rate counts as one; read all zeros
	task automatic test_read_extremes();
		set_rate(16'd0);
		run_transaction(REQ_READ, 8'h7f, 8'hff, 10, 0, 1'b0);
	endtask

	// requests while busy and on the finishing tick must be ignored
	task automatic test_busy_requests();
		set_rate(16'd1);
		run_transaction(REQ_WRITE, 8'h00, 8'hff, 2, 2, 1'b1);
	endtask

	// largest rate only with idle ticks
	task automatic test_rate_extremes();
		set_rate(16'hffff);
		for (int i = 0; i < 8; i++) begin
			send_tick(random_tick(1'b0));
		end
	endtask

	// random traffic over three idling patterns
	task automatic test_random();
		logic [15:0] rates[3] = '{16'd1, 16'd0, 16'd1};
		for (int seg = 0; seg < 3; seg++) begin
			case (seg)
				0: begin
					tx_pct = 20;
					rx_pct = 49;
				end
				1: begin
					tx_pct = 49;
					rx_pct = 20;
				end
				default: begin
					tx_pct = 0;
					rx_pct = 0;
				end
			endcase
			set_rate(rates[seg]);
			for (int i = 0; i < 30; i++) begin
				send_tick(random_tick(1'b1));
			end
			// let the running transaction end before the rate changes
			while (bus.ph != PH_IDLE) begin
				send_tick(random_tick(1'b0));
			end
		end
	endtask

	initial begin
		bus = '0;
		bus.ph = PH_IDLE;
		bus.scl = 1'b1;
		bus.sda = 1'b1;
		bus.drv = 1'b1;
		rate = TICKS_RESET;
		tx_pct = 20;
		rx_pct = 49;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_rate();
		test_write_extremes();
		test_read_extremes();
		test_busy_requests();
		test_rate_extremes();
		test_random();

		wait_results();
		repeat (SETTLE_CYCLES + 3) @(posedge clk);
		$display("covered %0d ticks: %0d writes and %0d reads started, %0d finished",
			ticks_sent, writes_started, reads_started, finished);
		$display("rates 0, 1, 100 and 65535, a rate drop inside a delay, held acknowledges");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== two_wire_register_master_core.f =====
+incdir+sv
sv/twrm_pkg.sv
sv/twrm_engine.sv
sv/two_wire_register_master_core.sv
sv/twrm_checker.sv
sim/two_wire_register_master_core_tb.sv
